@@ rtl/csc_pkg.sv @@
// Shared types and constants for the colour space converter.
// Depends on nothing; every module of the converter imports it.
package csc_pkg;

    // Input format codes
    localparam logic CMD_RGB  = 1'b0;
    localparam logic CMD_CMYK = 1'b1;

    // (2^16 - 1)^2, the full-scale product of two ink complements
    localparam logic [31:0] INK_FULL_SQ = 32'd4294836225;

    // Side data that travels beside the dividers
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] key;
        logic [15:0] lightness;
        logic        black_px;
        logic        grey_px;
    } side_t;

endpackage

@@ rtl/csc_cmyk.sv @@
// Front end of the converter: selects RGB or turns CMYK into RGB.
// Three register stages. Depends on csc_pkg.
module csc_cmyk (
    input  logic        clk,
    input  logic        cmd,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [15:0] cyan,
    input  logic [15:0] magenta,
    input  logic [15:0] yellow,
    input  logic [15:0] black,
    output logic [7:0]  red_rgb,
    output logic [7:0]  green_rgb,
    output logic [7:0]  blue_rgb
);
    import csc_pkg::*;

    logic [31:0] prod_reg [3];
    logic        cmd1_reg, cmd2_reg;
    logic [23:0] rgb1_reg, rgb2_reg;
    logic [39:0] scaled_reg [3];
    logic [7:0]  qest_reg [3];
    logic [7:0]  chan_next [3];
    logic [39:0] scaled_next [3];
    logic [40:0] check [3];
    logic [8:0]  qinc [3];

    // Stage one: multiply the ink complements
    always_ff @(posedge clk)
    begin
        prod_reg[0] <= {16'b0, ~cyan}    * {16'b0, ~black};
        prod_reg[1] <= {16'b0, ~magenta} * {16'b0, ~black};
        prod_reg[2] <= {16'b0, ~yellow}  * {16'b0, ~black};
        cmd1_reg    <= cmd;
        rgb1_reg    <= {red, green, blue};
    end

    // Stage two: scale by 255 and estimate the quotient
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scaled_next[i] = {prod_reg[i], 8'b0} - 40'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            scaled_reg[i] <= scaled_next[i];
            qest_reg[i]   <= scaled_next[i][39:32];
        end
        cmd2_reg <= cmd1_reg;
        rgb2_reg <= rgb1_reg;
    end

    // Stage three: correct the estimate by at most one and pick the format
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qinc[i]  = 9'(qest_reg[i]) + 9'd1;
            check[i] = 41'(qinc[i]) * 41'(INK_FULL_SQ);
            chan_next[i] = (check[i] <= 41'(scaled_reg[i])) ? qinc[i][7:0] : qest_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd2_reg == CMD_CMYK)
        begin
            red_rgb   <= chan_next[0];
            green_rgb <= chan_next[1];
            blue_rgb  <= chan_next[2];
        end
        else
        begin
            red_rgb   <= rgb2_reg[23:16];
            green_rgb <= rgb2_reg[15:8];
            blue_rgb  <= rgb2_reg[7:0];
        end
    end

endmodule

@@ rtl/csc_prep.sv @@
// Extremes, hue sector and divider operands for one pixel.
// Two register stages. Depends on csc_pkg.
module csc_prep #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic [7:0]              red,
    input  logic [7:0]              green,
    input  logic [7:0]              blue,
    output logic [23:0]             cyan_num,
    output logic [23:0]             magenta_num,
    output logic [23:0]             yellow_num,
    output logic [7:0]              max_den,
    output logic [23:0]             sat_num,
    output logic [7:0]              sat_den,
    output logic [FRAC_BITS+10:0]   hue_num,
    output logic [10:0]             hue_den,
    output csc_pkg::side_t          side
);
    import csc_pkg::*;

    logic [7:0]  r_reg, g_reg, b_reg, mx_reg, mn_reg;
    logic [7:0]  mx_next, mn_next, d, dr, dg, db;
    logic [8:0]  sum;
    logic [10:0] t;
    logic [16:0] light_full;

    // Find largest and smallest channel
    always_comb
    begin
        mx_next = (red > green) ? red : green;
        mx_next = (mx_next > blue) ? mx_next : blue;
        mn_next = (red < green) ? red : green;
        mn_next = (mn_next < blue) ? mn_next : blue;
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= red;
        g_reg  <= green;
        b_reg  <= blue;
        mx_reg <= mx_next;
        mn_reg <= mn_next;
    end

    // Form the operands; red wins ties, then green
    always_comb
    begin
        d   = mx_reg - mn_reg;
        sum = 9'(mx_reg) + 9'(mn_reg);
        dr  = mx_reg - r_reg;
        dg  = mx_reg - g_reg;
        db  = mx_reg - b_reg;
        if (mx_reg == r_reg)
        begin
            if (g_reg >= b_reg)
                t = 11'(g_reg - b_reg);
            else
                t = 11'(6) * 11'(d) - 11'(b_reg - g_reg);
        end
        else if (mx_reg == g_reg)
            t = 11'(2) * 11'(d) + 11'(b_reg) - 11'(r_reg);
        else
            t = 11'(4) * 11'(d) + 11'(r_reg) - 11'(g_reg);
        light_full = {sum, 8'b0} + 17'(sum);
    end

    always_ff @(posedge clk)
    begin
        cyan_num    <= {dr, 16'b0} - 24'(dr);
        magenta_num <= {dg, 16'b0} - 24'(dg);
        yellow_num  <= {db, 16'b0} - 24'(db);
        max_den     <= mx_reg;
        sat_num     <= {d, 16'b0} - 24'(d);
        sat_den     <= (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
        hue_num     <= {t, {FRAC_BITS{1'b0}}};
        hue_den     <= {d, 2'b0} + {2'b0, d, 1'b0};
        side.red       <= r_reg;
        side.green     <= g_reg;
        side.blue      <= b_reg;
        side.key       <= {~mx_reg, ~mx_reg};
        side.lightness <= light_full[16:1];
        side.black_px  <= (mx_reg == 8'd0);
        side.grey_px   <= (d == 8'd0);
    end

endmodule

@@ rtl/csc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, plus pad stages.
// Quotient must fit in QW bits. Depends on csc_pkg.
module csc_div #(
    parameter int DW  = 8,
    parameter int QW  = 16,
    parameter int PAD = 0
) (
    input  logic             clk,
    input  logic [DW+QW-1:0] num,
    input  logic [DW-1:0]    den,
    output logic [QW-1:0]    quo
);
    import csc_pkg::*;

    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [DW-1:0] den_reg [QW+1];

    assign rem_reg[0] = num[DW+QW-1:QW];
    assign low_reg[0] = num[QW-1:0];
    assign q_reg[0]   = '0;
    assign den_reg[0] = den;

    // Advance one quotient bit per stage
    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW:0]   trial;
        logic          fits;
        logic [DW-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[i], low_reg[i][QW-1]};
            fits     = (trial >= {1'b0, den_reg[i]});
            rem_next = fits ? DW'(trial - {1'b0, den_reg[i]}) : trial[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= rem_next;
            low_reg[i+1] <= low_reg[i] << 1;
            q_reg[i+1]   <= {q_reg[i][QW-2:0], fits};
            den_reg[i+1] <= den_reg[i];
        end
    end

    // Hold the quotient for the pad stages
    if (PAD > 0)
    begin : g_pad
        logic [QW-1:0] pad_reg [PAD];
        always_ff @(posedge clk)
        begin
            pad_reg[0] <= q_reg[QW];
            for (int j = 1; j < PAD; j++)
                pad_reg[j] <= pad_reg[j-1];
        end
        assign quo = pad_reg[PAD-1];
    end
    else
    begin : g_nopad
        assign quo = q_reg[QW];
    end

endmodule

@@ rtl/color_space_converter_unit.sv @@
// Top level of the colour space converter: RGB or CMYK in, RGB/CMYK/HSL out.
// Depends on csc_pkg, csc_cmyk, csc_prep and csc_div.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  request  | start, busy        | cmd, red, green, blue, cyan, magenta, ...
//  result   | done (one cycle)   | red_out ... key_out, hue, saturation, ...
//
// One request per cycle is taken; busy stays low. Each result is carried
// through the CMYK front end, the operand stage, the pipelined dividers
// (one quotient bit a stage) and the output register. Reset clears only
// the valid pipeline. The receiver cannot stall, so nothing ever holds.
module color_space_converter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [15:0] cyan,
    input  logic [15:0] magenta,
    input  logic [15:0] yellow,
    input  logic [15:0] black,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [15:0] cyan_out,
    output logic [15:0] magenta_out,
    output logic [15:0] yellow_out,
    output logic [15:0] key_out,
    output logic [15:0] hue,
    output logic [15:0] saturation,
    output logic [15:0] lightness
);
    import csc_pkg::*;

    localparam int LAT   = (FRAC_BITS > 16) ? FRAC_BITS : 16;
    localparam int DEPTH = 6 + LAT;

    logic [DEPTH-1:0]        vld_reg;
    logic [7:0]              r_c, g_c, b_c, max_den, sat_den;
    logic [23:0]             c_num, m_num, y_num, s_num;
    logic [FRAC_BITS+10:0]   h_num;
    logic [10:0]             h_den;
    logic [15:0]             c_q, m_q, y_q, s_q;
    logic [FRAC_BITS-1:0]    h_q;
    logic [15:0]             hue_next;
    side_t                   side_in;
    side_t                   side_reg [LAT];

    assign busy = 1'b0;

    // Advance the valid bits beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DEPTH-2:0], start};
    end

    assign done = vld_reg[DEPTH-1];

    csc_cmyk u_cmyk (
        .clk       (clk),
        .cmd       (cmd),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .cyan      (cyan),
        .magenta   (magenta),
        .yellow    (yellow),
        .black     (black),
        .red_rgb   (r_c),
        .green_rgb (g_c),
        .blue_rgb  (b_c)
    );

    csc_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk         (clk),
        .red         (r_c),
        .green       (g_c),
        .blue        (b_c),
        .cyan_num    (c_num),
        .magenta_num (m_num),
        .yellow_num  (y_num),
        .max_den     (max_den),
        .sat_num     (s_num),
        .sat_den     (sat_den),
        .hue_num     (h_num),
        .hue_den     (h_den),
        .side        (side_in)
    );

    csc_div #(.DW(8), .QW(16), .PAD(LAT-16)) u_div_c (
        .clk(clk), .num(c_num), .den(max_den), .quo(c_q));
    csc_div #(.DW(8), .QW(16), .PAD(LAT-16)) u_div_m (
        .clk(clk), .num(m_num), .den(max_den), .quo(m_q));
    csc_div #(.DW(8), .QW(16), .PAD(LAT-16)) u_div_y (
        .clk(clk), .num(y_num), .den(max_den), .quo(y_q));
    csc_div #(.DW(8), .QW(16), .PAD(LAT-16)) u_div_s (
        .clk(clk), .num(s_num), .den(sat_den), .quo(s_q));
    csc_div #(.DW(11), .QW(FRAC_BITS), .PAD(LAT-FRAC_BITS)) u_div_h (
        .clk(clk), .num(h_num), .den(h_den), .quo(h_q));

    // Delay the side data to meet the quotients
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int j = 1; j < LAT; j++)
            side_reg[j] <= side_reg[j-1];
    end

    // Bring the hue to 16 fraction bits
    if (FRAC_BITS >= 16)
    begin : g_hue_cut
        assign hue_next = h_q[FRAC_BITS-1 -: 16];
    end
    else
    begin : g_hue_wide
        assign hue_next = {h_q, {(16-FRAC_BITS){1'b0}}};
    end

    // Register the result, zeroing the black and grey cases
    always_ff @(posedge clk)
    begin
        red_out     <= side_reg[LAT-1].red;
        green_out   <= side_reg[LAT-1].green;
        blue_out    <= side_reg[LAT-1].blue;
        key_out     <= side_reg[LAT-1].key;
        lightness   <= side_reg[LAT-1].lightness;
        cyan_out    <= side_reg[LAT-1].black_px ? 16'd0 : c_q;
        magenta_out <= side_reg[LAT-1].black_px ? 16'd0 : m_q;
        yellow_out  <= side_reg[LAT-1].black_px ? 16'd0 : y_q;
        saturation  <= side_reg[LAT-1].grey_px  ? 16'd0 : s_q;
        hue         <= side_reg[LAT-1].grey_px  ? 16'd0 : hue_next;
    end

    // A grey result has no hue and no saturation
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        done && red_out == green_out && green_out == blue_out
        |-> hue == 16'd0 && saturation == 16'd0)
        else $error("grey pixel with hue or saturation");

    // Full key means black, so no ink
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        done && key_out == 16'hFFFF
        |-> cyan_out == 16'd0 && magenta_out == 16'd0 && yellow_out == 16'd0)
        else $error("black pixel with ink");

    // A coloured pixel always has some saturation
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && hue != 16'd0 |-> saturation != 16'd0)
        else $error("hue without saturation");

endmodule
